// ===== hdl/nmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// nmtp_pkg
// Shared constants, codes and request types of the nested mode time profiler.
// ----------------------------------------------------------------------------
package nmtp_pkg;

    localparam int MODE_COUNT  = 5;
    localparam int STACK_DEPTH = 16;
    localparam int COUNT_WIDTH = 48;

    localparam int KIND_W   = 3;
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 48;
    localparam int STATUS_W = 2;
    localparam int NEST_W   = 5;

    localparam int CIDX_W  = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
    localparam int SIDX_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    localparam logic [MODE_W-1:0] OTHER_RESET = MODE_W'(4);

    typedef enum logic [KIND_W-1:0] {
        K_TICK   = 3'd0,
        K_START  = 3'd1,
        K_STOP   = 3'd2,
        K_INIT   = 3'd3,
        K_FINISH = 3'd4,
        K_READ   = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MODE_W-1:0] mode;
    } t_in_req;

    typedef struct packed {
        logic [VALUE_W-1:0]  count_value;
        logic [STATUS_W-1:0] status;
        logic [NEST_W-1:0]   nesting_depth;
    } t_out_req;

endpackage

// ===== hdl/nested_mode_time_profiler.sv =====
// ----------------------------------------------------------------------------
// nested_mode_time_profiler
// Mode stack with exclusive per-mode tick counters, saturating totals,
// finish-time attribution of unclaimed ticks and counter read-back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_req  (t_in_req)
//  out     | output    | o_out_valid / i_out_stall| o_out_req (t_out_req)
//  cfg     | input     | i_cfg_we                 | i_cfg_wdata (other mode)
//
//  One request per cycle while o_in_stall is low. A result passes the stage
//  two register and then the output register: stage one updates stack and
//  total and issues the counter memory read, stage two gets the read data.
//  Reset clears stack depth, total, the counter valid bits and the sum.
//  A stalled output holds the whole pipe and o_in_stall goes high.
// ----------------------------------------------------------------------------
module nested_mode_time_profiler
    import nmtp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_req             i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_req            o_out_req,
    input  logic                i_cfg_we,
    input  logic [MODE_W-1:0]   i_cfg_wdata
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        COP_NONE,
        COP_INC,
        COP_ADD,
        COP_INIT,
        COP_READ
    } t_cop;

    typedef enum logic [1:0] {
        CQ_MEM,
        CQ_FWD,
        CQ_ZERO
    } t_cq_sel;

    typedef struct packed {
        t_cop                   cop;
        logic                   is_read;
        logic [CIDX_W-1:0]      addr;
        logic [COUNT_WIDTH-1:0] total;
        t_status                status;
        logic [DEPTH_W-1:0]     depth;
    } t_s2;

    // memories
    logic [MODE_W-1:0]      stack_mem [STACK_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem   [MODE_COUNT];

    // control state
    logic [MODE_W-1:0]      r_other_idx;
    logic [DEPTH_W-1:0]     r_depth,  n_depth;
    logic [MODE_W-1:0]      r_top,    n_top;
    logic [COUNT_WIDTH-1:0] r_total,  n_total;
    logic [COUNT_WIDTH-1:0] r_attr,   n_attr;
    logic [MODE_COUNT-1:0]  r_cnt_vld;
    logic                   r_s2_valid;
    logic                   r_out_valid;

    // payload
    t_s2                    r_s2, n_s2;
    logic [MODE_W-1:0]      r_bq_mem;
    logic                   r_bq_fwd;
    logic [MODE_W-1:0]      r_bq_fd;
    logic [COUNT_WIDTH-1:0] r_cq_mem;
    t_cq_sel                r_cq_sel, n_cq_sel;
    logic [COUNT_WIDTH-1:0] r_cq_fd;
    t_out_req               r_out_req, n_out_req;

    logic                   en;
    logic                   push;
    logic                   stk_we;
    logic [SIDX_W-1:0]      stk_waddr;
    logic [SIDX_W-1:0]      stk_raddr;
    logic [MODE_W-1:0]      below;
    logic                   mode_ok;
    logic                   top_ok;
    logic                   other_ok;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   s2_init;
    logic [COUNT_WIDTH-1:0] value;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign below    = r_bq_fwd ? r_bq_fd : r_bq_mem;
    assign mode_ok  = 32'(i_in_req.mode) < MODE_COUNT;
    assign top_ok   = 32'(r_top) < MODE_COUNT;
    assign other_ok = 32'(r_other_idx) < MODE_COUNT;

    // stage one: stack, total, counter address
    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        n_total = r_total;
        push    = 1'b0;
        n_s2.cop     = COP_NONE;
        n_s2.is_read = 1'b0;
        n_s2.addr    = '0;
        n_s2.status  = ST_OK;
        if (i_in_valid) begin
            case (t_kind'(i_in_req.kind))
                K_TICK: begin
                    n_total = (r_total == CNT_MAX) ? CNT_MAX : r_total + 1'b1;
                    if (r_depth != '0 && top_ok) begin
                        n_s2.cop  = COP_INC;
                        n_s2.addr = r_top[CIDX_W-1:0];
                    end
                end
                K_START: begin
                    if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                        n_s2.status = ST_FULL;
                    end else begin
                        push    = 1'b1;
                        n_top   = i_in_req.mode;
                        n_depth = r_depth + 1'b1;
                    end
                end
                K_STOP: begin
                    if (r_depth == '0) begin
                        n_s2.status = ST_EMPTY;
                    end else if (r_top != i_in_req.mode) begin
                        n_s2.status = ST_MISMATCH;
                    end else begin
                        n_top   = below;
                        n_depth = r_depth - 1'b1;
                    end
                end
                K_INIT: begin
                    n_total  = '0;
                    n_s2.cop = COP_INIT;
                end
                K_FINISH: begin
                    if (other_ok) begin
                        n_s2.cop  = COP_ADD;
                        n_s2.addr = r_other_idx[CIDX_W-1:0];
                    end
                end
                K_READ: begin
                    n_s2.is_read = 1'b1;
                    if (mode_ok) begin
                        n_s2.cop  = COP_READ;
                        n_s2.addr = i_in_req.mode[CIDX_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
        n_s2.total = n_total;
        n_s2.depth = n_depth;
    end

    assign stk_we    = en && push && (r_depth != '0);
    assign stk_waddr = SIDX_W'(r_depth - 1'b1);
    assign stk_raddr = SIDX_W'(n_depth - 2'd2);

    // stage two: counter read-modify-write
    always_comb begin
        case (r_cq_sel)
            CQ_MEM:  cnt = r_cq_mem;
            CQ_FWD:  cnt = r_cq_fd;
            default: cnt = '0;
        endcase
        cnt_we    = 1'b0;
        cnt_wdata = cnt + 1'b1;
        n_attr    = r_attr;
        s2_init   = 1'b0;
        if (r_s2_valid) begin
            case (r_s2.cop)
                COP_INC: begin
                    if (cnt != CNT_MAX) begin
                        cnt_we = 1'b1;
                        n_attr = (r_attr == CNT_MAX) ? CNT_MAX : r_attr + 1'b1;
                    end
                end
                COP_ADD: begin
                    if (r_s2.total > r_attr) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt + (r_s2.total - r_attr);
                        n_attr    = r_s2.total;
                    end
                end
                COP_INIT: begin
                    s2_init = 1'b1;
                    n_attr  = '0;
                end
                default: begin
                end
            endcase
        end
        cnt_we = cnt_we && en;

        if (cnt_we && r_s2.addr == n_s2.addr) begin
            n_cq_sel = CQ_FWD;
        end else if (s2_init || !r_cnt_vld[n_s2.addr]) begin
            n_cq_sel = CQ_ZERO;
        end else begin
            n_cq_sel = CQ_MEM;
        end

        if (r_s2.is_read) begin
            value = (r_s2.cop == COP_READ) ? cnt : '0;
        end else begin
            value = r_s2.total;
        end
        n_out_req.count_value   = VALUE_W'(value);
        n_out_req.status        = r_s2.status;
        n_out_req.nesting_depth = NEST_W'(r_s2.depth);
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= r_top;
        end
        if (en) begin
            r_bq_mem <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[r_s2.addr] <= cnt_wdata;
        end
        if (en) begin
            r_cq_mem <= cnt_mem[n_s2.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bq_fwd  <= push;
            r_bq_fd   <= r_top;
            r_cq_sel  <= n_cq_sel;
            r_cq_fd   <= cnt_wdata;
            r_s2      <= n_s2;
            r_out_req <= n_out_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_other_idx <= OTHER_RESET;
            r_depth     <= '0;
            r_top       <= '0;
            r_total     <= '0;
            r_attr      <= '0;
            r_cnt_vld   <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_other_idx <= i_cfg_wdata;
            end
            if (en) begin
                r_depth     <= n_depth;
                r_top       <= n_top;
                r_total     <= n_total;
                r_attr      <= n_attr;
                r_s2_valid  <= i_in_valid;
                r_out_valid <= r_s2_valid;
                if (s2_init) begin
                    r_cnt_vld <= '0;
                end else if (cnt_we) begin
                    r_cnt_vld[r_s2.addr] <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_s2_valid) && $stable(r_attr)
            && $stable(r_total) && $stable(r_depth))
        else $error("pipe moved under output stall");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.status == ST_FULL)
            |-> o_out_req.nesting_depth == NEST_W'(STACK_DEPTH))
        else $error("full status with stack not full");

    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> r_s2_valid && (r_s2.cop == COP_INC || r_s2.cop == COP_ADD))
        else $error("counter write without counting request");
`endif

endmodule

// ===== verif/nmtp_profile_checker.sv =====
// ----------------------------------------------------------------------------
// nmtp_profile_checker
// Watches the request and result channels of the nested mode time profiler.
// Every accepted request is run through a local profile model: mode stack,
// saturating per-mode ticks, total and finish attribution. Each accepted
// result is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module nmtp_profile_checker
    import nmtp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_req           i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_req          i_out_req,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata,
    output int                o_fail_count,
    output int                o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam t_count COUNT_MAX   = '1;

    logic [MODE_W-1:0]  held_modes [STACK_DEPTH];
    logic [DEPTH_W-1:0] held_depth;
    t_count             mode_ticks [MODE_COUNT];
    t_count             all_ticks;
    logic [MODE_W-1:0]  spill_mode;
    t_out_req           expected_results [$];
    int                 n_fail = 0;

    assign o_fail_count = n_fail;

    function automatic t_count sat_add(t_count a, t_count b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        n_fail++;
    endtask

    function automatic t_out_req profile_step(t_in_req r);
        t_out_req          res;
        t_count            claimed;
        logic [MODE_W-1:0] top;
        logic [SIDX_W-1:0] slot;
        res.status = ST_OK;
        slot = SIDX_W'(held_depth - 1'b1);
        case (r.kind)
            K_TICK: begin
                all_ticks = sat_add(all_ticks, t_count'(1));
                if (held_depth != 0) begin
                    top = held_modes[slot];
                    if (top < MODE_COUNT)
                        mode_ticks[top] = sat_add(mode_ticks[top], t_count'(1));
                end
            end
            K_START: begin
                if (held_depth >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    held_modes[SIDX_W'(held_depth)] = r.mode;
                    held_depth++;
                end
            end
            K_STOP: begin
                if (held_depth == 0)
                    res.status = ST_EMPTY;
                else if (held_modes[slot] != r.mode)
                    res.status = ST_MISMATCH;
                else
                    held_depth--;
            end
            K_INIT: begin
                foreach (mode_ticks[i]) mode_ticks[i] = '0;
                all_ticks = '0;
            end
            K_FINISH: begin
                claimed = '0;
                foreach (mode_ticks[i]) claimed = sat_add(claimed, mode_ticks[i]);
                if (all_ticks > claimed && spill_mode < MODE_COUNT)
                    mode_ticks[spill_mode] = sat_add(mode_ticks[spill_mode],
                                                     all_ticks - claimed);
            end
            default: ;
        endcase
        res.count_value = VALUE_W'(all_ticks);
        if (r.kind == K_READ) begin
            res.count_value = '0;
            if (r.mode < MODE_COUNT)
                res.count_value = VALUE_W'(mode_ticks[r.mode]);
        end
        res.nesting_depth = NEST_W'(held_depth);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            held_depth = '0;
            all_ticks  = '0;
            spill_mode = OTHER_RESET;
            foreach (mode_ticks[i]) mode_ticks[i] = '0;
            foreach (held_modes[i]) held_modes[i] = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                spill_mode = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 64'(i_out_req), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_req.count_value !== want.count_value)
                        report_mismatch("count_value", 64'(i_out_req.count_value),
                                        64'(want.count_value));
                    if (i_out_req.status !== want.status)
                        report_mismatch("status", 64'(i_out_req.status),
                                        64'(want.status));
                    if (i_out_req.nesting_depth !== want.nesting_depth)
                        report_mismatch("nesting_depth", 64'(i_out_req.nesting_depth),
                                        64'(want.nesting_depth));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(profile_step(i_in_req));
        end
        o_waiting <= expected_results.size();
    end

endmodule

// ===== verif/tb_nested_mode_time_profiler.sv =====
// ----------------------------------------------------------------------------
// tb_nested_mode_time_profiler
// Stimulus and verdict for the nested mode time profiler. A directed run
// covers empty and full stack, stop mismatch, stray modes and finish; then
// four random phases with different sender idling and receiver stalls,
// each under its own other-mode setting, push stack depth up and down.
// ----------------------------------------------------------------------------
module tb_nested_mode_time_profiler;
    timeunit 1ns;
    timeprecision 1ps;
    import nmtp_pkg::*;

    localparam int                CLK_HALF       = 4;
    localparam int                RESET_CYCLES   = 8;
    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                DRAIN_CYCLES   = 8;
    localparam int                PHASE_ITEMS    = 460;
    localparam int                SWING_ITEMS    = 64;
    localparam logic [KIND_W-1:0] K_SPARE_LO     = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_HI     = 3'd7;
    localparam logic [MODE_W-1:0] MODE_STRAY     = '1;
    localparam logic [MODE_W-1:0] MODE_NONE      = MODE_W'(MODE_COUNT + 1);

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_req            in_req    = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [MODE_W-1:0]  cfg_wdata = OTHER_RESET;
    logic               in_stall;
    logic               out_valid;
    t_out_req           out_req;
    int                 fail_count;
    int                 waiting;
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;
    logic [MODE_W-1:0]  live_modes [$];

    always #(CLK_HALF) i_clk = ~i_clk;

    nested_mode_time_profiler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    nmtp_profile_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_req(input logic [KIND_W-1:0] k, input logic [MODE_W-1:0] m);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        in_req.kind <= k;
        in_req.mode <= m;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (k == K_START && live_modes.size() < STACK_DEPTH)
            live_modes.push_back(m);
        if (k == K_STOP && live_modes.size() > 0 && live_modes[$] == m)
            void'(live_modes.pop_back());
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    task automatic write_other_mode(input logic [MODE_W-1:0] v);
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(9) < 8)
            return MODE_W'($urandom_range(MODE_COUNT - 1));
        return MODE_W'($urandom_range(2**MODE_W - 1, MODE_COUNT));
    endfunction

    task automatic random_req(input bit climb);
        int                pick;
        int                start_end;
        int                stop_end;
        logic [MODE_W-1:0] m;
        pick      = $urandom_range(99);
        start_end = climb ? 69 : 45;
        stop_end  = 79;
        if (pick < 35) begin
            send_req(K_TICK, MODE_W'($urandom_range(2**MODE_W - 1)));
        end else if (pick < start_end) begin
            send_req(K_START, pick_mode());
        end else if (pick < stop_end) begin
            if (live_modes.size() > 0 && $urandom_range(99) < 85)
                m = live_modes[$];
            else
                m = MODE_W'($urandom_range(2**MODE_W - 1));
            send_req(K_STOP, m);
        end else if (pick < 82) begin
            send_req(K_INIT, MODE_W'($urandom_range(2**MODE_W - 1)));
        end else if (pick < 87) begin
            send_req(K_FINISH, MODE_W'($urandom_range(2**MODE_W - 1)));
        end else if (pick < 97) begin
            send_req(K_READ, pick_mode());
        end else begin
            send_req($urandom_range(1) ? K_SPARE_LO : K_SPARE_HI,
                     MODE_W'($urandom_range(2**MODE_W - 1)));
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [MODE_W-1:0] other);
        write_other_mode(other);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
                quiesce();
            random_req((n / SWING_ITEMS) % 2 == 0);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        send_req(K_TICK, '0);
        send_req(K_STOP, '0);
        send_req(K_READ, MODE_STRAY);
        send_req(K_START, MODE_STRAY);
        send_req(K_TICK, '0);
        send_req(K_STOP, MODE_W'(2));
        send_req(K_STOP, MODE_STRAY);
        send_req(K_FINISH, '0);
        send_req(K_READ, OTHER_RESET);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_req(K_START, MODE_W'(i % MODE_COUNT));
        send_req(K_TICK, '0);
        send_req(K_FINISH, '0);
        send_req(K_READ, '0);
        send_req(K_READ, OTHER_RESET);
        send_req(K_INIT, '0);
        send_req(K_SPARE_HI, MODE_STRAY);

        run_phase(0, 0, '0);
        run_phase(53, 0, MODE_W'(MODE_COUNT - 1));
        run_phase(0, 53, MODE_NONE);
        run_phase(30, 30, MODE_W'(2));

        stall_pct = 0;
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/nmtp_pkg.sv
hdl/nested_mode_time_profiler.sv
verif/nmtp_profile_checker.sv
verif/tb_nested_mode_time_profiler.sv
